### rtl/apc_pkg.sv
// Shared constants, types and the identifier helper function for the Art-Net packet classifier.
`timescale 1ns / 1ps
`default_nettype none

package apc_pkg;

   localparam int UNIVERSES        = 256;
   localparam int MAX_PACKET_BYTES = 16383;

   localparam int UNIV_IDX_W = $clog2(UNIVERSES);
   localparam int LEN_W      = $clog2(MAX_PACKET_BYTES + 1);

   localparam int MIN_LEN_W  = 14;
   localparam int UNIV_W     = 8;
   localparam int OPC_W      = 16;
   localparam int CNT_W      = 32;
   localparam int BYTES_W    = 48;
   localparam int STAMP_W    = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 14;

   localparam logic [OPC_W-1:0] OPC_SYNC = 16'h0052;
   localparam logic [OPC_W-1:0] OPC_DMX  = 16'h0050;

   localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET    = 14'd100;
   localparam logic [UNIV_W-1:0]    FIRST_UNIV_RESET = 8'd0;
   localparam logic [UNIV_W-1:0]    LAST_UNIV_RESET  = 8'd255;

   // Byte positions of interest within the packet.
   localparam int IDENT_LEN    = 7;
   localparam int OPC_HI_POS   = 8;
   localparam int OPC_LO_POS   = 9;
   localparam int UNIVERSE_POS = 14;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_LEN    = 2'd0,
      CSR_FIRST_UNIV = 2'd1,
      CSR_LAST_UNIV  = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      KIND_DMX     = 3'd0,
      KIND_SYNC    = 3'd1,
      KIND_UNKNOWN = 3'd2,
      KIND_WINDOW  = 3'd3,
      KIND_INVALID = 3'd4
   } kind_type;

   // Expected identifier characters, "Art-Net".
   function automatic logic [7:0] ident_byte(input logic [2:0] pos);
      logic [7:0] ch;
      unique case (pos)
         3'd0:    ch = 8'h41;
         3'd1:    ch = 8'h72;
         3'd2:    ch = 8'h74;
         3'd3:    ch = 8'h2D;
         3'd4:    ch = 8'h4E;
         3'd5:    ch = 8'h65;
         3'd6:    ch = 8'h74;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

### rtl/artnet_packet_classifier_top.sv
// Art-Net packet classifier: byte-stream header parser, per-universe statistics, result stage.
`timescale 1ns / 1ps
`default_nettype none
// Timing: the final byte of a packet is registered in the packet end register, and its result
// beat moves on into the result register once that register is not holding a stalled result.
// Throughput: one byte per cycle while the input is not stalled; a result only holds the input
// back when it is stalled while the following packet end is already waiting behind it.
// Reset (synchronous, active high) clears the counters, the header state and the per-universe
// valid bits, and loads the configuration registers with their reset values; no clearing pass
// is needed, so bytes flow right after reset.

module artnet_packet_classifier_top (
   input  wire                                     clock,
   input  wire                                     reset,

   input  wire                                     req_valid,
   output logic                                    req_stall,
   input  wire  [7:0]                              req_data_byte,
   input  wire                                     req_last_byte,
   input  wire  [apc_pkg::STAMP_W-1:0]             req_now_seconds,

   output logic                                    rsp_valid,
   input  wire                                     rsp_stall,
   output logic [2:0]                              rsp_packet_kind,
   output logic [apc_pkg::OPC_W-1:0]               rsp_opcode_seen,
   output logic [apc_pkg::UNIV_W-1:0]              rsp_universe_seen,
   output logic [apc_pkg::CNT_W-1:0]               rsp_universe_updates,
   output logic [apc_pkg::CNT_W-1:0]               rsp_total_packets,
   output logic [apc_pkg::BYTES_W-1:0]             rsp_total_bytes,
   output logic [apc_pkg::CNT_W-1:0]               rsp_total_ignored,
   output logic [apc_pkg::CNT_W-1:0]               rsp_total_invalid,

   input  wire                                     csr_write_enable,
   input  wire  [apc_pkg::CSR_IDX_W-1:0]           csr_index,
   input  wire  [apc_pkg::CSR_DATA_W-1:0]          csr_write_data
);

   import apc_pkg::*;

   // ---------------------------------------------------------------------------------------
   // Configuration registers. Writes must arrive only while idle; the block does not enforce this.
   // ---------------------------------------------------------------------------------------
   logic [MIN_LEN_W-1:0] min_len_ff;
   logic [UNIV_W-1:0]    first_univ_ff;
   logic [UNIV_W-1:0]    last_univ_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff    <= MIN_LEN_RESET;
         first_univ_ff <= FIRST_UNIV_RESET;
         last_univ_ff  <= LAST_UNIV_RESET;
      end else if (csr_write_enable) begin
         // An index beyond the register list is simply ignored.
         priority case (csr_index)
            CSR_MIN_LEN:    min_len_ff    <= csr_write_data;
            CSR_FIRST_UNIV: first_univ_ff <= csr_write_data[UNIV_W-1:0];
            CSR_LAST_UNIV:  last_univ_ff  <= csr_write_data[UNIV_W-1:0];
            default:        ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------------------
   // Header parsing. The first seven bytes of a packet are checked against the identifier, and
   // the opcode and universe bytes are captured at their fixed offsets. The length counter
   // saturates, while the running byte total keeps counting every beat.
   // ---------------------------------------------------------------------------------------
   logic [LEN_W-1:0]   offset_ff,   offset_in;
   logic               ident_ok_ff, ident_ok_in;
   logic [OPC_W-1:0]   opcode_ff,   opcode_in;
   logic [UNIV_W-1:0]  universe_ff, universe_in;
   logic [BYTES_W-1:0] bytes_ff,    bytes_in;

   logic req_accept;
   logic req_accept_last;

   assign req_accept      = req_valid && !req_stall;
   assign req_accept_last = req_accept && req_last_byte;

   always_comb begin
      ident_ok_in = ident_ok_ff;
      if ((offset_ff < LEN_W'(IDENT_LEN)) &&
          (req_data_byte != ident_byte(offset_ff[2:0]))) begin
         ident_ok_in = 1'b0;
      end

      opcode_in = opcode_ff;
      if (offset_ff == LEN_W'(OPC_HI_POS)) begin
         opcode_in = {req_data_byte, opcode_ff[7:0]};
      end
      if (offset_ff == LEN_W'(OPC_LO_POS)) begin
         opcode_in = {opcode_ff[15:8], req_data_byte};
      end

      universe_in = universe_ff;
      if (offset_ff == LEN_W'(UNIVERSE_POS)) begin
         universe_in = req_data_byte;
      end

      offset_in = offset_ff;
      if (offset_ff < LEN_W'(MAX_PACKET_BYTES)) begin
         offset_in = offset_ff + LEN_W'(1);
      end

      bytes_in = bytes_ff + BYTES_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff   <= '0;
         ident_ok_ff <= 1'b1;
         opcode_ff   <= '0;
         universe_ff <= '0;
         bytes_ff    <= '0;
      end else if (req_accept) begin
         bytes_ff <= bytes_in;
         if (req_last_byte) begin
            // The packet is complete: start the header state afresh for the next one.
            offset_ff   <= '0;
            ident_ok_ff <= 1'b1;
            opcode_ff   <= '0;
            universe_ff <= '0;
         end else begin
            offset_ff   <= offset_in;
            ident_ok_ff <= ident_ok_in;
            opcode_ff   <= opcode_in;
            universe_ff <= universe_in;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Packet end register. The final byte's header summary is registered here alongside the statistics
   // table read, and the classification and the table update happen as it moves into the result register.
   // ---------------------------------------------------------------------------------------
   logic                 end_vld_ff;
   logic [LEN_W-1:0]     end_len_ff;
   logic                 end_ident_ff;
   logic [OPC_W-1:0]     end_opcode_ff;
   logic [UNIV_W-1:0]    end_univ_ff;
   logic [BYTES_W-1:0]   end_bytes_ff;
   logic [STAMP_W-1:0]   end_now_ff;

   logic out_free;
   logic end_move;

   assign out_free  = !rsp_valid || !rsp_stall;
   assign end_move  = end_vld_ff && out_free;
   // Bytes keep flowing unless a finished packet is stuck behind a stalled result.
   assign req_stall = end_vld_ff && !out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         end_vld_ff <= 1'b0;
      end else if (req_accept_last) begin
         end_vld_ff <= 1'b1;
      end else if (end_move) begin
         end_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept_last) begin
         end_len_ff    <= offset_in;
         end_ident_ff  <= ident_ok_in;
         end_opcode_ff <= opcode_in;
         end_univ_ff   <= universe_in;
         end_bytes_ff  <= bytes_in;
         end_now_ff    <= req_now_seconds;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Per-universe tables. The update counts live in a memory with one valid bit per entry,
   // so an entry not yet written reads as zero. The activity stamps are only ever written.
   // The read happens as the final byte is accepted; the write follows once the packet end moves
   // on to the result register. A DMX packet needs at least ten bytes, so two table updates never overlap.
   // ---------------------------------------------------------------------------------------
   logic [CNT_W-1:0]   upd_mem [UNIVERSES];
   logic [STAMP_W-1:0] act_mem [UNIVERSES];
   logic [UNIVERSES-1:0] upd_vld_ff;

   logic [UNIV_IDX_W-1:0] rd_addr;
   logic [UNIV_IDX_W-1:0] wr_addr;
   logic [CNT_W-1:0]      upd_rd_ff;
   logic                  upd_rd_vld_ff;
   logic                  upd_we;
   logic [CNT_W-1:0]      upd_new;

   assign rd_addr = universe_in[UNIV_IDX_W-1:0];
   assign wr_addr = end_univ_ff[UNIV_IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (req_accept_last) begin
         upd_rd_ff     <= upd_mem[rd_addr];
         upd_rd_vld_ff <= upd_vld_ff[rd_addr];
      end
      if (upd_we) begin
         upd_mem[wr_addr] <= upd_new;
         act_mem[wr_addr] <= end_now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upd_vld_ff <= '0;
      end else if (upd_we) begin
         upd_vld_ff[wr_addr] <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Classification. The length test comes first, then the identifier, then the sync opcode,
   // then any opcode other than DMX. A DMX packet counts against its universe before the
   // window test, so an out-of-window universe still has its count raised.
   // ---------------------------------------------------------------------------------------
   kind_type          kind;
   logic              tracked;
   logic              in_window;
   logic              is_dmx_path;
   logic [CNT_W-1:0]  upd_old;
   logic [CNT_W-1:0]  updates;

   logic [CNT_W-1:0] pkt_ff, pkt_in;
   logic [CNT_W-1:0] ign_ff, ign_in;
   logic [CNT_W-1:0] inv_ff, inv_in;

   always_comb begin
      tracked   = ({1'b0, end_univ_ff} < (UNIV_W + 1)'(UNIVERSES));
      in_window = (end_univ_ff >= first_univ_ff) && (end_univ_ff <= last_univ_ff);

      priority if ((32'(end_len_ff) < 32'(min_len_ff)) || !end_ident_ff ||
                   (end_len_ff < LEN_W'(IDENT_LEN))) begin
         kind = KIND_INVALID;
      end else if (end_opcode_ff == OPC_SYNC) begin
         kind = KIND_SYNC;
      end else if (end_opcode_ff != OPC_DMX) begin
         kind = KIND_UNKNOWN;
      end else if (!in_window) begin
         kind = KIND_WINDOW;
      end else begin
         kind = KIND_DMX;
      end

      is_dmx_path = (kind == KIND_DMX) || (kind == KIND_WINDOW);
      upd_old     = upd_rd_vld_ff ? upd_rd_ff : '0;
      upd_new     = upd_old + CNT_W'(1);
      upd_we      = end_move && is_dmx_path && tracked;
      updates     = (is_dmx_path && tracked) ? upd_new : '0;

      pkt_in = pkt_ff + CNT_W'(1);
      ign_in = ign_ff;
      inv_in = inv_ff;
      if ((kind == KIND_UNKNOWN) || (kind == KIND_WINDOW)) begin
         ign_in = ign_ff + CNT_W'(1);
      end
      if (kind == KIND_INVALID) begin
         inv_in = inv_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_ff <= '0;
         ign_ff <= '0;
         inv_ff <= '0;
      end else if (end_move) begin
         pkt_ff <= pkt_in;
         ign_ff <= ign_in;
         inv_ff <= inv_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Result register. It holds a beat while the consumer stalls.
   // ---------------------------------------------------------------------------------------
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= end_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (end_move) begin
         rsp_packet_kind      <= kind;
         rsp_opcode_seen      <= end_opcode_ff;
         rsp_universe_seen    <= end_univ_ff;
         rsp_universe_updates <= updates;
         rsp_total_packets    <= pkt_in;
         rsp_total_bytes      <= end_bytes_ff;
         rsp_total_ignored    <= ign_in;
         rsp_total_invalid    <= inv_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // ---------------------------------------------------------------------------------------
   // Checks.
   // ---------------------------------------------------------------------------------------
   a_blocked_end_stalls_input: assert property (@(posedge clock) disable iff (reset)
      (end_vld_ff && !out_free) |-> req_stall)
      else $error("packet end blocked behind a result but input not stalled");

   a_table_write_dmx_only: assert property (@(posedge clock) disable iff (reset)
      upd_we |-> ((kind == KIND_DMX) || (kind == KIND_WINDOW)))
      else $error("universe table written for a packet that is not DMX");

   a_header_restarts: assert property (@(posedge clock) disable iff (reset)
      req_accept_last |=> ((offset_ff == '0) && ident_ok_ff && (opcode_ff == '0)))
      else $error("header state not cleared after the final byte");

   a_result_from_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(end_vld_ff))
      else $error("result beat raised without a packet end behind it");

   a_packet_total_steps: assert property (@(posedge clock) disable iff (reset)
      end_move |=> (pkt_ff == ($past(pkt_ff) + CNT_W'(1))))
      else $error("packet total did not advance by one per result");

endmodule

`default_nettype wire
